// File: hw/rtl/cosine_feature_match_table_top_macros.svh
// assertion helpers for the match table rtl, included by cfmt_back
`ifndef COSINE_FEATURE_MATCH_TABLE_TOP_MACROS_SVH
`define COSINE_FEATURE_MATCH_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CFMT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CFMT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cfmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_pkg
// Shared codes, field widths and handoff types of the feature match table.
// ----------------------------------------------------------------------------
package cfmt_pkg;

	localparam int KEY_W        = 32;
	localparam int IN_ELEM_W    = 16;
	localparam int SCORE_W      = 16;
	localparam int SLOT_FIELD_W = 6;
	localparam int CNT_FIELD_W  = 10;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam logic [1:0] FN_STORE  = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_NO_MATCH  = 2'd3;

	typedef struct packed {
		logic [1:0]             op;
		logic [KEY_W-1:0]       key;
		logic [CNT_FIELD_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [KEY_W-1:0]        key;
		logic [SCORE_W-1:0]      score;
		logic                    above;
	} res_t;

endpackage
`default_nettype wire

// File: hw/rtl/cfmt_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_isqrt
// Integer square root, floor, one result bit per cycle.
// ----------------------------------------------------------------------------
module cfmt_isqrt import cfmt_pkg::*; #(
	parameter int IN_W   = 38,
	parameter int ROOT_W = 19
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [IN_W-1:0]   value,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int PAD_W  = 2 * ROOT_W;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PAD_W-1:0]  val_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+2:0] rem_in;
	logic [ROOT_W+2:0] trial;
	logic              ge;
	logic [ROOT_W+2:0] rem_nx;

	// remainder never exceeds twice the partial root, so its top bit stays clear
	always_comb begin
		rem_in = {rem_q[ROOT_W:0], val_q[PAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_in >= trial;
		rem_nx = ge ? rem_in - trial : rem_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= PAD_W'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= rem_nx[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// File: hw/rtl/cfmt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_front
// Takes input beats, buffers vector elements and queues commands.
// ----------------------------------------------------------------------------
module cfmt_front import cfmt_pkg::*; #(
	parameter int FEATURE_LEN  = 128,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [47:0]                      s_axis_tdata,
	input  wire logic [1:0]                       s_axis_tuser,
	input  wire logic                             s_axis_tlast,
	input  wire logic                             vec_done,
	output logic                                  bw_en,
	output logic [$clog2(FEATURE_LEN)-1:0]        bw_addr,
	output logic [ELEMENT_BITS-1:0]               bw_data,
	output logic                                  cmd_valid,
	output cmd_t                                  cmd,
	input  wire logic                             cmd_pop
);

	localparam int IDX_W  = $clog2(FEATURE_LEN);
	localparam int CNT_W  = $clog2(FEATURE_LEN + 1);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              vec_busy_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	cmd_t              queue_q [QUEUE_DEPTH];

	logic              accept;
	logic [1:0]        func;
	logic              is_vec;
	logic              room;
	logic [CNT_W-1:0]  cnt_inc;
	logic              push;
	cmd_t              push_cmd;
	logic [31:0]       raw_ext;

	always_comb begin
		accept  = s_axis_tvalid && s_axis_tready;
		func    = s_axis_tuser;
		is_vec  = (func == FN_STORE) || (func == FN_QUERY);
		room    = cnt_q < CNT_W'(FEATURE_LEN);
		cnt_inc = room ? cnt_q + 1'b1 : cnt_q;
		push    = accept && ((func == FN_DELETE) || (is_vec && s_axis_tlast));
		push_cmd.op    = func;
		push_cmd.key   = s_axis_tdata[KEY_W-1:0];
		push_cmd.count = (func == FN_DELETE) ? '0 : CNT_FIELD_W'(cnt_inc);
		raw_ext = {16'b0, s_axis_tdata[KEY_W +: IN_ELEM_W]};
	end

	// element field is read as two's complement in its low ELEMENT_BITS bits
	assign bw_en   = accept && is_vec && room;
	assign bw_addr = cnt_q[IDX_W-1:0];
	assign bw_data = raw_ext[ELEMENT_BITS-1:0];

	assign s_axis_tready = (fill_q != FILL_W'(QUEUE_DEPTH)) && !vec_busy_q;
	assign cmd_valid     = fill_q != '0;
	assign cmd           = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			vec_busy_q <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fill_q     <= '0;
		end else begin
			if (accept) begin
				if (func == FN_DELETE) begin
					cnt_q <= '0;
				end else if (is_vec) begin
					cnt_q <= s_axis_tlast ? '0 : cnt_inc;
				end
			end
			// buffer stays owned by the back end until it finishes the vector
			if (accept && is_vec && s_axis_tlast) begin
				vec_busy_q <= 1'b1;
			end else if (vec_done) begin
				vec_busy_q <= 1'b0;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + FILL_W'(push) - FILL_W'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/cfmt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_back
// Slot table, feature memory and the scoring sequencer.
// ----------------------------------------------------------------------------
module cfmt_back import cfmt_pkg::*; #(
	parameter int SLOTS        = 64,
	parameter int FEATURE_LEN  = 128,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [SCORE_W-1:0]               threshold,
	input  wire logic                             bw_en,
	input  wire logic [$clog2(FEATURE_LEN)-1:0]   bw_addr,
	input  wire logic [ELEMENT_BITS-1:0]          bw_data,
	input  wire logic                             cmd_valid,
	input  wire cmd_t                             cmd,
	output logic                                  cmd_pop,
	output logic                                  vec_done,
	output logic                                  res_valid,
	output res_t                                  res,
	input  wire logic                             res_ready
);

	`include "cosine_feature_match_table_top_macros.svh"

	localparam int IDX_W  = $clog2(FEATURE_LEN);
	localparam int CNT_W  = $clog2(FEATURE_LEN + 1);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SCNT_W = $clog2(SLOTS + 1);
	localparam int FS_AW  = $clog2(SLOTS * FEATURE_LEN);
	localparam int PROD_W = 2 * ELEMENT_BITS;
	localparam int ACC_W  = 2 * ELEMENT_BITS + IDX_W;
	localparam int ROOT_W = (ACC_W + 1) / 2;
	localparam int D_W    = 2 * ROOT_W;
	localparam int NUM_W  = D_W + 2;
	localparam int DIV_W  = $clog2(SCORE_W);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_COPY_RD, ST_COPY_WR,
		ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_SQRT_GO, ST_SQRT,
		ST_SLOT, ST_MULD, ST_NUM, ST_DIV, ST_CMP, ST_FIN,
		ST_KEY_RD, ST_KEY_USE, ST_RESULT
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [SLOTS-1:0]         valid_q;
	logic [SCNT_W-1:0]        scan_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     hit_found_q;
	logic [SLOT_W-1:0]        hit_q;
	logic                     free_found_q;
	logic [SLOT_W-1:0]        free_q;
	logic [SLOT_W-1:0]        target_q;
	logic                     pass_nq_q;
	logic signed [ACC_W-1:0]  acc_qq_q;
	logic signed [ACC_W-1:0]  acc_qr_q;
	logic signed [ACC_W-1:0]  acc_rr_q;
	logic signed [PROD_W-1:0] pqq_s2;
	logic signed [PROD_W-1:0] pqr_s2;
	logic signed [PROD_W-1:0] prr_s2;
	logic [ROOT_W-1:0]        rq_q;
	logic [ROOT_W-1:0]        rs_q;
	logic [D_W-1:0]           d_q;
	logic [NUM_W-1:0]         rem_q;
	logic [SCORE_W-1:0]       quo_q;
	logic [DIV_W-1:0]         div_cnt_q;
	logic [SCORE_W-1:0]       sc_q;
	logic [SCORE_W-1:0]       best_q;
	logic [SLOT_W-1:0]        best_slot_q;
	logic                     best_found_q;
	res_t                     res_q;

	logic [ELEMENT_BITS-1:0]  buf_mem [FEATURE_LEN];
	logic [ELEMENT_BITS-1:0]  fs_mem  [SLOTS * FEATURE_LEN];
	logic [KEY_W-1:0]         key_mem [SLOTS];
	logic [ELEMENT_BITS-1:0]  buf_rd_s1;
	logic [ELEMENT_BITS-1:0]  fs_rd_s1;
	logic [KEY_W-1:0]         key_rd_s1;

	logic [SLOT_W-1:0]        scan_idx;
	logic [IDX_W-1:0]         elem_idx;
	logic                     last_idx;
	logic                     in_vec;
	logic                     match;
	logic                     hit_f;
	logic [SLOT_W-1:0]        hit_s;
	logic                     free_f;
	logic [SLOT_W-1:0]        free_s;
	logic                     fs_we;
	logic [ELEMENT_BITS-1:0]  fs_wdata;
	logic [FS_AW-1:0]         fs_waddr;
	logic [FS_AW-1:0]         fs_raddr;
	logic                     key_we;
	logic signed [ELEMENT_BITS-1:0] q_el;
	logic signed [ELEMENT_BITS-1:0] r_el;
	logic                     sq_start;
	logic [ACC_W-1:0]         sq_value;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;
	logic signed [NUM_W-1:0]  num;
	logic [NUM_W-1:0]         two_d;
	logic [NUM_W-1:0]         d_ext;
	logic                     div_ge;
	logic [NUM_W-1:0]         rem_nx;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+SLOT_FIELD_W-1:0] w;
		w = {{SLOT_FIELD_W{1'b0}}, s};
		return w[SLOT_FIELD_W-1:0];
	endfunction

	always_comb begin
		scan_idx = scan_q[SLOT_W-1:0];
		elem_idx = idx_q[IDX_W-1:0];
		last_idx = idx_q == CNT_W'(FEATURE_LEN - 1);
		in_vec   = CNT_FIELD_W'(idx_q) < cmd_q.count;
		match    = valid_q[scan_idx] && (key_rd_s1 == cmd_q.key);
		hit_f    = hit_found_q || match;
		hit_s    = hit_found_q ? hit_q : scan_idx;
		free_f   = free_found_q || !valid_q[scan_idx];
		free_s   = free_found_q ? free_q : scan_idx;
		fs_we    = state_q == ST_COPY_WR;
		fs_wdata = in_vec ? buf_rd_s1 : '0;
		fs_waddr = FS_AW'(target_q) * FS_AW'(FEATURE_LEN) + FS_AW'(elem_idx);
		fs_raddr = FS_AW'(scan_idx) * FS_AW'(FEATURE_LEN) + FS_AW'(elem_idx);
		key_we   = (state_q == ST_COPY_WR) && last_idx;
		q_el     = in_vec ? signed'(buf_rd_s1) : '0;
		r_el     = signed'(fs_rd_s1);
		sq_start = state_q == ST_SQRT_GO;
		sq_value = pass_nq_q ? unsigned'(acc_qq_q) : unsigned'(acc_rr_q);
		d_ext    = NUM_W'(d_q);
		num      = NUM_W'(acc_qr_q) + signed'(d_ext);
		two_d    = {1'b0, d_q, 1'b0};
		div_ge   = rem_q >= d_ext;
		rem_nx   = div_ge ? rem_q - d_ext : rem_q;
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid = state_q == ST_RESULT;
	assign res       = res_q;
	assign vec_done  = (state_q == ST_RESULT) && res_ready && (cmd_q.op != FN_DELETE);

	always_ff @(posedge clk) begin
		if (bw_en) begin
			buf_mem[bw_addr] <= bw_data;
		end
		buf_rd_s1 <= buf_mem[elem_idx];
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		fs_rd_s1 <= fs_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[target_q] <= cmd_q.key;
		end
		key_rd_s1 <= key_mem[scan_idx];
	end

	cfmt_isqrt #(
		.IN_W   (ACC_W),
		.ROOT_W (ROOT_W)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_value),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			cmd_q        <= '0;
			scan_q       <= '0;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			hit_q        <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			target_q     <= '0;
			pass_nq_q    <= 1'b0;
			best_found_q <= 1'b0;
			best_q       <= '0;
			best_slot_q  <= '0;
			div_cnt_q    <= '0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd;
						scan_q       <= '0;
						idx_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						best_q       <= '0;
						pass_nq_q    <= 1'b1;
						state_q      <= (cmd.op == FN_QUERY) ? ST_MAC_RD : ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					hit_found_q  <= hit_f;
					hit_q        <= hit_s;
					free_found_q <= free_f;
					free_q       <= free_s;
					if (scan_q != SCNT_W'(SLOTS - 1)) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end else if (cmd_q.op == FN_DELETE) begin
						res_q <= '0;
						if (hit_f) begin
							valid_q[hit_s] <= 1'b0;
							res_q.status   <= STAT_OK;
							res_q.slot     <= slot_field(hit_s);
						end else begin
							res_q.status <= STAT_NOT_FOUND;
						end
						state_q <= ST_RESULT;
					end else if (hit_f || free_f) begin
						target_q <= hit_f ? hit_s : free_s;
						idx_q    <= '0;
						state_q  <= ST_COPY_RD;
					end else begin
						res_q        <= '0;
						res_q.status <= STAT_NO_SPACE;
						state_q      <= ST_RESULT;
					end
				end
				ST_COPY_RD: begin
					state_q <= ST_COPY_WR;
				end
				ST_COPY_WR: begin
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						valid_q[target_q] <= 1'b1;
						res_q             <= '0;
						res_q.status      <= STAT_OK;
						res_q.slot        <= slot_field(target_q);
						state_q           <= ST_RESULT;
					end else begin
						state_q <= ST_COPY_RD;
					end
				end
				ST_MAC_RD: begin
					if (idx_q == '0) begin
						acc_qq_q <= '0;
						acc_qr_q <= '0;
						acc_rr_q <= '0;
					end
					state_q <= ST_MAC_MUL;
				end
				ST_MAC_MUL: begin
					pqq_s2  <= q_el * q_el;
					pqr_s2  <= q_el * r_el;
					prr_s2  <= r_el * r_el;
					state_q <= ST_MAC_ACC;
				end
				ST_MAC_ACC: begin
					acc_qq_q <= acc_qq_q + ACC_W'(pqq_s2);
					acc_qr_q <= acc_qr_q + ACC_W'(pqr_s2);
					acc_rr_q <= acc_rr_q + ACC_W'(prr_s2);
					idx_q    <= idx_q + 1'b1;
					state_q  <= last_idx ? ST_SQRT_GO : ST_MAC_RD;
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done) begin
						if (pass_nq_q) begin
							rq_q      <= sq_root;
							pass_nq_q <= 1'b0;
							scan_q    <= '0;
							state_q   <= (sq_root == '0) ? ST_FIN : ST_SLOT;
						end else begin
							rs_q <= sq_root;
							if (sq_root == '0) begin
								scan_q  <= scan_q + 1'b1;
								state_q <= ST_SLOT;
							end else begin
								state_q <= ST_MULD;
							end
						end
					end
				end
				ST_SLOT: begin
					if (scan_q == SCNT_W'(SLOTS)) begin
						state_q <= ST_FIN;
					end else if (!valid_q[scan_idx]) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						idx_q   <= '0;
						state_q <= ST_MAC_RD;
					end
				end
				ST_MULD: begin
					d_q     <= D_W'(rq_q) * D_W'(rs_q);
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					if (num <= 0) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_SLOT;
					end else if (unsigned'(num) >= two_d) begin
						sc_q    <= SCORE_MAX;
						state_q <= ST_CMP;
					end else begin
						rem_q     <= unsigned'(num);
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring divide, remainder kept below twice the divisor
					rem_q     <= rem_nx << 1;
					quo_q     <= {quo_q[SCORE_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_W'(SCORE_W - 1)) begin
						sc_q    <= {quo_q[SCORE_W-2:0], div_ge};
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (sc_q > best_q) begin
						best_q       <= sc_q;
						best_slot_q  <= scan_idx;
						best_found_q <= 1'b1;
					end
					scan_q  <= scan_q + 1'b1;
					state_q <= ST_SLOT;
				end
				ST_FIN: begin
					if (best_found_q) begin
						scan_q  <= SCNT_W'(best_slot_q);
						state_q <= ST_KEY_RD;
					end else begin
						res_q        <= '0;
						res_q.status <= STAT_NO_MATCH;
						state_q      <= ST_RESULT;
					end
				end
				ST_KEY_RD: begin
					state_q <= ST_KEY_USE;
				end
				ST_KEY_USE: begin
					res_q.status <= STAT_OK;
					res_q.slot   <= slot_field(best_slot_q);
					res_q.key    <= key_rd_s1;
					res_q.score  <= best_q;
					res_q.above  <= best_q > threshold;
					state_q      <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CFMT_ASSERT_IMP(a_pop_needs_cmd, cmd_pop, cmd_valid, "command taken from empty queue")
	`CFMT_ASSERT_IMP(a_div_rem_range, state_q == ST_DIV, rem_q < {1'b0, d_q, 1'b0}, "divide remainder out of range")
	`CFMT_ASSERT_IMP(a_best_nonzero, best_found_q, best_q != '0, "winning score is zero")
	`CFMT_ASSERT_NXT(a_result_to_idle, res_valid && res_ready, state_q == ST_IDLE, "result beat not retired")

endmodule
`default_nettype wire

// File: hw/rtl/cosine_feature_match_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_feature_match_table_top
// Keyed feature vector table with cosine similarity best-match search.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                       tuser    tlast
//  s_axis    in   entry_key, element                       func     last_element
//  m_axis    out  slot, matched_key, score, above_thresh   status   -
//  cfg       in   match_threshold on cfg_we                -        -
//
//  non-final vector beats only fill the buffer and queue no command; a delete scans every slot
//  a store scans every slot, then copies the buffered vector into the hit or a free slot
//  a query sums its own norm and takes its square root, then walks the slots: an empty
//  slot is skipped, a valid one gets its dot product, norm square root (ROOT_W is the
//  square root width, 20 here) and score in turn
//  s_axis stalls while a vector command is being worked or the command queue is full
//  reset clears all slot valid bits at once; there is no clearing pass
module cosine_feature_match_table_top import cfmt_pkg::*; #(
	parameter int SLOTS        = 64,
	parameter int FEATURE_LEN  = 128,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // entry_key, element
	input  wire logic [1:0]  s_axis_tuser,   // func
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // slot, matched_key, score, above_threshold
	output logic [1:0]       m_axis_tuser,   // status
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic                           bw_en;
	logic [$clog2(FEATURE_LEN)-1:0] bw_addr;
	logic [ELEMENT_BITS-1:0]        bw_data;
	logic                           cmd_valid;
	cmd_t                           cmd;
	logic                           cmd_pop;
	logic                           vec_done;
	logic                           res_valid;
	res_t                           res;
	logic                           res_ready;
	logic [SCORE_W-1:0]             threshold_q;
	logic                           out_valid_q;
	res_t                           out_q;

	cfmt_front #(
		.FEATURE_LEN  (FEATURE_LEN),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.vec_done      (vec_done),
		.bw_en         (bw_en),
		.bw_addr       (bw_addr),
		.bw_data       (bw_data),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	cfmt_back #(
		.SLOTS        (SLOTS),
		.FEATURE_LEN  (FEATURE_LEN),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.bw_en     (bw_en),
		.bw_addr   (bw_addr),
		.bw_data   (bw_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.vec_done  (vec_done),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register frees the sequencer as soon as the beat is parked
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {1'b0, out_q.above, out_q.score, out_q.key, out_q.slot};

endmodule
`default_nettype wire

// File: test/cfmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmt_checker
// Watches the stream, result and threshold ports of the feature match table,
// keeps its own copy of the table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module cfmt_checker import cfmt_pkg::*; #(
	parameter int SLOTS       = 64,
	parameter int FEATURE_LEN = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          pending
);

	logic [15:0]   threshold;
	bit            occupied [SLOTS];
	logic [31:0]   slot_key [SLOTS];
	shortint       features [SLOTS][FEATURE_LEN];
	shortint       vec_buf [FEATURE_LEN];
	int            fill;
	res_t          expected_q [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n   = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic int find_key(logic [31:0] key);
		for (int s = 0; s < SLOTS; s++)
			if (occupied[s] && slot_key[s] == key)
				return s;
		return -1;
	endfunction

	function automatic res_t best_match();
		res_t          r;
		longint        nq;
		longint        best;
		int            best_slot;
		longint        dot;
		longint        ns;
		longint        d;
		longint        num;
		longint        sc;
		longint unsigned rq;
		longint unsigned rs;
		r         = '0;
		nq        = 0;
		best      = 0;
		best_slot = -1;
		for (int i = 0; i < FEATURE_LEN; i++)
			nq += longint'(vec_buf[i]) * vec_buf[i];
		rq = int_sqrt(nq);
		if (rq != 0) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (!occupied[s])
					continue;
				dot = 0;
				ns  = 0;
				for (int i = 0; i < FEATURE_LEN; i++) begin
					dot += longint'(vec_buf[i]) * features[s][i];
					ns  += longint'(features[s][i]) * features[s][i];
				end
				rs = int_sqrt(ns);
				if (rs == 0)
					continue;
				d   = longint'(rq * rs);
				num = (dot + d) * 32768;
				sc  = (num <= 0) ? 0 : num / d;
				if (sc > 65535)
					sc = 65535;
				if (sc > best) begin
					best      = sc;
					best_slot = s;
				end
			end
		end
		if (best_slot < 0) begin
			r.status = STAT_NO_MATCH;
		end else begin
			r.status = STAT_OK;
			r.slot   = best_slot[SLOT_FIELD_W-1:0];
			r.key    = slot_key[best_slot];
			r.score  = best[SCORE_W-1:0];
			r.above  = (best > threshold);
		end
		return r;
	endfunction

	task automatic take_beat(logic [1:0] func, logic [31:0] key, shortint elem, logic last);
		res_t r;
		int   s;
		r = '0;
		if (func == FN_DELETE) begin
			fill = 0;
			s    = find_key(key);
			if (s < 0) begin
				r.status = STAT_NOT_FOUND;
			end else begin
				occupied[s] = 0;
				r.slot      = s[SLOT_FIELD_W-1:0];
			end
			expected_q.insert(expected_q.size(), r);
		end else if (func == FN_STORE || func == FN_QUERY) begin
			if (fill < FEATURE_LEN) begin
				vec_buf[fill] = elem;
				fill++;
			end
			if (last) begin
				for (int i = fill; i < FEATURE_LEN; i++)
					vec_buf[i] = 0;
				fill = 0;
				if (func == FN_QUERY) begin
					r = best_match();
				end else begin
					s = find_key(key);
					if (s < 0)
						for (int i = 0; i < SLOTS; i++)
							if (!occupied[i]) begin
								s = i;
								break;
							end
					if (s < 0) begin
						r.status = STAT_NO_SPACE;
					end else begin
						occupied[s] = 1;
						slot_key[s] = key;
						features[s] = vec_buf;
						r.slot      = s[SLOT_FIELD_W-1:0];
					end
				end
				expected_q.insert(expected_q.size(), r);
			end
		end
	endtask

	task automatic check_result();
		res_t e;
		res_t g;
		g.status = m_tuser;
		g.slot   = m_tdata[5:0];
		g.key    = m_tdata[37:6];
		g.score  = m_tdata[53:38];
		g.above  = m_tdata[54];
		if (expected_q.size() == 0) begin
			$error("result beat with no result outstanding: status %0d slot %0d",
				g.status, g.slot);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (g.status != e.status) begin
			$error("status: expected %0d, got %0d", e.status, g.status);
			errors++;
		end
		if (g.slot != e.slot) begin
			$error("slot: expected %0d, got %0d", e.slot, g.slot);
			errors++;
		end
		if (g.key != e.key) begin
			$error("matched_key: expected %h, got %h", e.key, g.key);
			errors++;
		end
		if (g.score != e.score) begin
			$error("score: expected %0d, got %0d", e.score, g.score);
			errors++;
		end
		if (g.above != e.above) begin
			$error("above_threshold: expected %0d, got %0d", e.above, g.above);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill      = 0;
			threshold = '0;
			for (int s = 0; s < SLOTS; s++)
				occupied[s] = 0;
		end else begin
			if (cfg_we)
				threshold = cfg_wdata;
			// retire before predicting so a new beat never pairs with an older result
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				take_beat(s_tuser, s_tdata[31:0], shortint'(s_tdata[47:32]), s_tlast);
			pending = expected_q.size();
		end
	end

endmodule

// File: test/tb_cosine_feature_match_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_feature_match_table_top
// Drives stores, deletes, queries and threshold writes into the match table
// with random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cosine_feature_match_table_top;
	import cfmt_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int         NUM_KEYS  = 16;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // entry_key, element
	logic [1:0]  s_axis_tuser = '0;   // func
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;        // slot, matched_key, score, above_threshold
	logic [1:0]  m_axis_tuser;        // status
	logic        cfg_we = 0;
	logic [15:0] cfg_wdata = '0;

	int          errors;
	int          pending;
	int          beats_sent = 0;
	bit          no_gaps = 0;
	int          hold_seq = 0;
	logic [31:0] key_pool [NUM_KEYS];
	shortint     saved_vec [$];

	always #4 clk = ~clk;

	cosine_feature_match_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	cfmt_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.s_tlast   (s_axis_tlast),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int seen_seq;
		int stall_left;
		int r;
		seen_seq   = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq   = hold_seq;
				stall_left = 3000;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 0;
				stall_left--;
			end else begin
				m_axis_tready <= 1;
				r = $urandom_range(0, 99);
				if (!no_gaps && r < 10)
					stall_left = $urandom_range(1, 3);
				else if (!no_gaps && r < 13)
					stall_left = $urandom_range(15, 60);
			end
		end
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic shortint rand_elem();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'sh8000;
		if (r < 16)
			return 16'sh7FFF;
		if (r < 55)
			return shortint'(int'($urandom_range(0, 4000)) - 2000);
		return shortint'($urandom);
	endfunction

	task automatic send_beat(logic [1:0] func, logic [31:0] key, shortint elem, logic last);
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70)
			n = 0;
		else if (r < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 50);
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {elem, key};
		s_axis_tuser  <= func;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	// only the final beat carries the real key
	task automatic send_vec(logic [1:0] func, logic [31:0] key, shortint v [$]);
		for (int i = 0; i < v.size(); i++)
			send_beat(func, (i == v.size() - 1) ? key : $urandom, v[i], i == v.size() - 1);
	endtask

	task automatic send_rand_vec(logic [1:0] func, logic [31:0] key, int len, bit reuse);
		shortint v [$];
		if (reuse && saved_vec.size() != 0) begin
			v = saved_vec;
		end else begin
			for (int i = 0; i < len; i++)
				v.insert(v.size(), rand_elem());
			saved_vec = v;
		end
		send_vec(func, key, v);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// covers beats that give no result but may still be in flight
		repeat (300) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_we    <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	task automatic random_phase(int nbeats);
		int stop;
		int r;
		int len;
		stop = beats_sent + nbeats;
		while (beats_sent < stop) begin
			r   = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 132)
				: $urandom_range(1, 6);
			if (r < 42)
				send_rand_vec(FN_STORE, key_pool[$urandom_range(0, NUM_KEYS-1)], len,
					$urandom_range(0, 4) == 0);
			else if (r < 55)
				send_beat(FN_DELETE, ($urandom_range(0, 5) == 0) ? $urandom
					: key_pool[$urandom_range(0, NUM_KEYS-1)], rand_elem(), 1'($urandom));
			else if (r < 87)
				send_rand_vec(FN_QUERY, $urandom, len, $urandom_range(0, 2) == 0);
			else if (r < 93)
				send_beat(FN_UNUSED, $urandom, rand_elem(), 1'($urandom));
			else
				// partial vector, dropped by a later delete or continued by the next vector beats
				send_beat($urandom_range(0, 1) ? FN_STORE : FN_QUERY, $urandom,
					rand_elem(), 0);
		end
	endtask

	initial begin
		shortint v [$];
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < NUM_KEYS; k++)
			key_pool[k] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed part
		write_threshold(16'd0);
		no_gaps = 1;
		send_vec(FN_QUERY, 32'h0, '{16'sd100, -16'sd5});        // empty table
		v = {};
		for (int i = 0; i < 128; i++)
			v.insert(v.size(), i[0] ? 16'sh7FFF : 16'sh8000);
		send_vec(FN_STORE, 32'hFFFF_FFFF, v);                   // full-length extremes
		send_vec(FN_STORE, 32'h0, '{16'sd16384});
		send_vec(FN_STORE, 32'h0000_00C0, '{16'sd0});           // zero-norm slot
		send_vec(FN_STORE, 32'hFFFF_FFFF, '{-16'sd300, 16'sd300}); // update in place
		send_vec(FN_QUERY, 32'h5, '{16'sd16384});               // exact match
		send_vec(FN_QUERY, 32'h6, '{-16'sd16384});              // opposite of key 0: the FFFF_FFFF row wins
		send_vec(FN_QUERY, 32'h7, '{16'sd0, 16'sd0});           // zero-norm query
		v = {};
		for (int i = 0; i < 131; i++)
			v.insert(v.size(), rand_elem());
		send_vec(FN_STORE, 32'hABCD_0001, v);                   // long vector
		send_beat(FN_UNUSED, 32'h1234_5678, 16'sd7, 1);
		send_beat(FN_UNUSED, 32'h1234_5678, 16'sd7, 0);
		send_beat(FN_STORE, 32'h9, 16'sd55, 0);                 // dropped by delete
		send_beat(FN_DELETE, 32'h0, 16'sd0, 0);
		send_beat(FN_DELETE, 32'h0, 16'sd0, 1);                 // now missing
		send_vec(FN_QUERY, 32'h8, '{16'sd100, 16'sd100});       // query against the remaining rows
		no_gaps = 0;
		wait_idle();

		// fill the table past capacity, query it full, then drain it under a hold-off
		write_threshold(16'hFFFF);
		for (int k = 0; k < 66; k++)
			send_rand_vec(FN_STORE, 32'h1000_0000 + k, $urandom_range(1, 3), 0);
		send_vec(FN_STORE, 32'h1000_0003, '{16'sd1000});
		send_rand_vec(FN_QUERY, 32'h0, 3, 0);
		wait_idle();
		hold_seq++;
		for (int k = 0; k < 66; k++)
			send_beat(FN_DELETE, 32'h1000_0000 + k, rand_elem(), 1);
		send_beat(FN_DELETE, 32'hFFFF_FFFF, 16'sd0, 1);
		send_beat(FN_DELETE, 32'h0000_00C0, 16'sd0, 1);
		send_beat(FN_DELETE, 32'hABCD_0001, 16'sd0, 1);
		wait_idle();

		// random part over several thresholds
		write_threshold(16'd0);
		random_phase(270);
		wait_idle();
		write_threshold(16'hFFFF);
		random_phase(270);
		wait_idle();
		write_threshold(16'h8000 + 16'($urandom_range(0, 8000)));
		no_gaps = 1;
		random_phase(90);
		no_gaps = 0;
		random_phase(180);
		wait_idle();
		write_threshold(16'($urandom));
		random_phase(270);
		wait_idle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
